// ----- hdl/moving_average_filter_top_assert.svh -----
// Assertion macros shared by the filter modules.
// Each macro expects signals named clk and rst_n in the module that uses it.
`ifndef MOVING_AVERAGE_FILTER_TOP_ASSERT_SVH
`define MOVING_AVERAGE_FILTER_TOP_ASSERT_SVH

// The property must hold in the same cycle as the condition.
`define MAF_ASSERT_SAME(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);

// The property must hold in the cycle after the condition.
`define MAF_ASSERT_NEXT(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);

`endif

// ----- hdl/maf_pkg.sv -----
package maf_pkg;

    // Defaults for the top-level parameters.
    localparam int MAX_WINDOW_DEF  = 64;
    localparam int SAMPLE_BITS_DEF = 16;

    // Fixed field widths of the register and the result.
    localparam int LEN_BITS   = 7;
    localparam int HELD_BITS  = 7;
    localparam int LEN_RESET  = 4;
    localparam int LEN_LIMIT  = 127;

    // Controller states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_UPDATE,
        ST_LOAD,
        ST_DIVIDE,
        ST_FINISH
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_in;
        logic rd_mem;
        logic update;
        logic load_div;
        logic div_step;
        logic load_out;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic div_last;
        logic out_free;
    } sts_t;

endpackage

// ----- hdl/moving_average_filter_top.sv -----
// Moving-average filter over the last window_length signed samples.
//
// Input beats arrive on the s_ group, one sample each; result beats leave on
// the m_ group, one per input beat, holding the average (running sum divided
// by the samples held, truncated toward zero) and the number of samples held.
// The user must set the window length via cfg_we and cfg_data while the block is
// idle (not enforced); a write clears the sum, write position and full flag.
//
// Items are processed one at a time: a new beat is accepted only once the
// previous one has passed through the read, update, load, divide and finish
// steps and the controller is idle again. The bit-serial restoring divider
// resolves one quotient bit per cycle over the sum width.
//
// Reset restores a window length of four and empties the window; the sample
// store itself is not cleared, as only written entries ever enter the sum.
// If the receiver stalls, the result waits in the output register; the block
// may accept and process the next sample meanwhile but holds its own result
// until the output register has been emptied.
module moving_average_filter_top
#(
    parameter int MAX_WINDOW  = maf_pkg::MAX_WINDOW_DEF,
    parameter int SAMPLE_BITS = maf_pkg::SAMPLE_BITS_DEF,
    localparam int IN_BITS    = ((SAMPLE_BITS + 7) / 8) * 8,
    localparam int OUT_BITS   = ((SAMPLE_BITS + maf_pkg::HELD_BITS + 7) / 8) * 8
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [maf_pkg::LEN_BITS-1:0] cfg_data,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [IN_BITS-1:0]           s_tdata,   // sample
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [OUT_BITS-1:0]          m_tdata    // average, samples_held
);

    maf_pkg::cmd_t cmd;
    maf_pkg::sts_t sts;

    logic [SAMPLE_BITS-1:0]        average;
    logic [maf_pkg::HELD_BITS-1:0] samples_held;

    // Sequencing of one item.
    maf_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // Window store, running sum, divider and output register.
    maf_datapath
    #(
        .MAX_WINDOW  (MAX_WINDOW),
        .SAMPLE_BITS (SAMPLE_BITS)
    )
    u_datapath
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_data     (cfg_data),
        .sample       (s_tdata[SAMPLE_BITS-1:0]),
        .m_tready     (m_tready),
        .cmd          (cmd),
        .sts          (sts),
        .m_tvalid     (m_tvalid),
        .average      (average),
        .samples_held (samples_held)
    );

    // Pack the result fields, lowest first, padded with zeros.
    assign m_tdata = OUT_BITS'({samples_held, average});

endmodule

// ----- hdl/maf_ctrl.sv -----
`include "moving_average_filter_top_assert.svh"

module maf_ctrl
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  maf_pkg::sts_t sts,
    output maf_pkg::cmd_t cmd
);

    maf_pkg::state_t state_reg;
    maf_pkg::state_t state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= maf_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next-state logic: one item walks through read, update, load, divide and finish.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            maf_pkg::ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = maf_pkg::ST_READ;
                end
            end
            maf_pkg::ST_READ:   state_next = maf_pkg::ST_UPDATE;
            maf_pkg::ST_UPDATE: state_next = maf_pkg::ST_LOAD;
            maf_pkg::ST_LOAD:   state_next = maf_pkg::ST_DIVIDE;
            maf_pkg::ST_DIVIDE:
            begin
                if (sts.div_last)
                begin
                    state_next = maf_pkg::ST_FINISH;
                end
            end
            maf_pkg::ST_FINISH:
            begin
                if (sts.out_free)
                begin
                    state_next = maf_pkg::ST_IDLE;
                end
            end
            default:            state_next = maf_pkg::ST_IDLE;
        endcase
    end

    // Output logic: one command per state.
    always_comb
    begin
        cmd      = '0;
        s_tready = 1'b0;
        unique case (state_reg)
            maf_pkg::ST_IDLE:
            begin
                s_tready    = 1'b1;
                cmd.load_in = s_tvalid;
            end
            maf_pkg::ST_READ:   cmd.rd_mem   = 1'b1;
            maf_pkg::ST_UPDATE: cmd.update   = 1'b1;
            maf_pkg::ST_LOAD:   cmd.load_div = 1'b1;
            maf_pkg::ST_DIVIDE: cmd.div_step = 1'b1;
            maf_pkg::ST_FINISH: cmd.load_out = sts.out_free;
            default:            cmd          = '0;
        endcase
    end

    // Only one item is in flight: after a beat is taken the input closes.
    `MAF_ASSERT_NEXT(a_one_in_flight, s_tvalid && s_tready, !s_tready,
        "input accepted twice in a row")

endmodule

// ----- hdl/maf_datapath.sv -----
`include "moving_average_filter_top_assert.svh"

module maf_datapath
#(
    parameter int MAX_WINDOW  = maf_pkg::MAX_WINDOW_DEF,
    parameter int SAMPLE_BITS = maf_pkg::SAMPLE_BITS_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [maf_pkg::LEN_BITS-1:0]  cfg_data,
    input  logic [SAMPLE_BITS-1:0]        sample,
    input  logic                          m_tready,
    input  maf_pkg::cmd_t                 cmd,
    output maf_pkg::sts_t                 sts,
    output logic                          m_tvalid,
    output logic [SAMPLE_BITS-1:0]        average,
    output logic [maf_pkg::HELD_BITS-1:0] samples_held
);

    localparam int LEN_BITS   = maf_pkg::LEN_BITS;
    localparam int HELD_BITS  = maf_pkg::HELD_BITS;
    localparam int POS_BITS   = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int EFF_MAX    = (MAX_WINDOW < maf_pkg::LEN_LIMIT) ? MAX_WINDOW
                                                                  : maf_pkg::LEN_LIMIT;
    localparam int TOTAL_BITS = SAMPLE_BITS + $clog2(EFF_MAX);
    localparam int CMP_BITS   = (POS_BITS + 1 > LEN_BITS) ? POS_BITS + 1 : LEN_BITS;
    localparam int CNT_BITS   = $clog2(TOTAL_BITS + 1);
    localparam int EXT_BITS   = TOTAL_BITS - SAMPLE_BITS;

    // Sample history.
    logic [SAMPLE_BITS-1:0] mem [MAX_WINDOW];

    // Filter state.
    logic [LEN_BITS-1:0]   len_reg,   len_next;
    logic [POS_BITS-1:0]   pos_reg,   pos_next;
    logic [TOTAL_BITS-1:0] total_reg, total_next;
    logic                  full_reg,  full_next;

    // Item payload and divider.
    logic [SAMPLE_BITS-1:0] sample_reg,  sample_next;
    logic [SAMPLE_BITS-1:0] rd_data_reg;
    logic [HELD_BITS-1:0]   held_reg,    held_next;
    logic                   neg_reg,     neg_next;
    logic [TOTAL_BITS-1:0]  dvd_reg,     dvd_next;
    logic [HELD_BITS-1:0]   rem_reg,     rem_next;
    logic [CNT_BITS-1:0]    cnt_reg,     cnt_next;

    // Output register.
    logic                   tvalid_reg,  tvalid_next;
    logic [SAMPLE_BITS-1:0] avg_reg,     avg_next;
    logic [HELD_BITS-1:0]   held_out_reg, held_out_next;

    // Working values.
    logic [TOTAL_BITS-1:0] sample_ext;
    logic [TOTAL_BITS-1:0] old_ext;
    logic [TOTAL_BITS-1:0] sum_new;
    logic [CMP_BITS-1:0]   pos_inc;
    logic                  wrap;
    logic                  full_new;
    logic [HELD_BITS:0]    shifted;
    logic [HELD_BITS:0]    trial;
    logic                  fits;
    logic [TOTAL_BITS-1:0] quot_signed;
    logic [LEN_BITS-1:0]   len_written;

    // Memory: read port registered, write on the update step.
    always_ff @(posedge clk)
    begin
        if (cmd.rd_mem)
        begin
            rd_data_reg <= mem[pos_reg];
        end
        if (cmd.update)
        begin
            mem[pos_reg] <= sample_reg;
        end
    end

    // Window update arithmetic.
    always_comb
    begin
        sample_ext = {{EXT_BITS{sample_reg[SAMPLE_BITS-1]}}, sample_reg};
        old_ext    = full_reg ? {{EXT_BITS{rd_data_reg[SAMPLE_BITS-1]}}, rd_data_reg}
                              : '0;
        sum_new    = total_reg - old_ext + sample_ext;
        pos_inc    = CMP_BITS'(pos_reg) + CMP_BITS'(1);
        wrap       = (pos_inc == CMP_BITS'(len_reg));
        full_new   = full_reg | wrap;
    end

    // Restoring divider step on the magnitude.
    always_comb
    begin
        shifted = {rem_reg, dvd_reg[TOTAL_BITS-1]};
        trial   = shifted - {1'b0, held_reg};
        fits    = (shifted >= {1'b0, held_reg});
        quot_signed = neg_reg ? (~dvd_reg + TOTAL_BITS'(1)) : dvd_reg;
    end

    // A written length of zero acts as one; lengths beyond the store saturate.
    always_comb
    begin
        if (cfg_data == '0)
        begin
            len_written = LEN_BITS'(1);
        end
        else if (32'(cfg_data) > 32'(EFF_MAX))
        begin
            len_written = LEN_BITS'(EFF_MAX);
        end
        else
        begin
            len_written = cfg_data;
        end
    end

    // Next-value logic for all registers.
    always_comb
    begin
        len_next      = len_reg;
        pos_next      = pos_reg;
        total_next    = total_reg;
        full_next     = full_reg;
        sample_next   = sample_reg;
        held_next     = held_reg;
        neg_next      = neg_reg;
        dvd_next      = dvd_reg;
        rem_next      = rem_reg;
        cnt_next      = cnt_reg;
        tvalid_next   = tvalid_reg;
        avg_next      = avg_reg;
        held_out_next = held_out_reg;

        if (cfg_we)
        begin
            len_next   = len_written;
            pos_next   = '0;
            total_next = '0;
            full_next  = 1'b0;
        end

        if (cmd.load_in)
        begin
            sample_next = sample;
        end

        if (cmd.update)
        begin
            total_next = sum_new;
            full_next  = full_new;
            pos_next   = wrap ? '0 : POS_BITS'(pos_inc);
            held_next  = full_new ? len_reg : HELD_BITS'(pos_inc);
        end

        if (cmd.load_div)
        begin
            neg_next = total_reg[TOTAL_BITS-1];
            dvd_next = total_reg[TOTAL_BITS-1] ? (~total_reg + TOTAL_BITS'(1)) : total_reg;
            rem_next = '0;
            cnt_next = '0;
        end

        if (cmd.div_step)
        begin
            rem_next = fits ? trial[HELD_BITS-1:0] : shifted[HELD_BITS-1:0];
            dvd_next = {dvd_reg[TOTAL_BITS-2:0], fits};
            cnt_next = cnt_reg + CNT_BITS'(1);
        end

        // The output register empties when its beat is taken.
        if (tvalid_reg && m_tready)
        begin
            tvalid_next = 1'b0;
        end
        if (cmd.load_out)
        begin
            tvalid_next   = 1'b1;
            avg_next      = quot_signed[SAMPLE_BITS-1:0];
            held_out_next = held_reg;
        end
    end

    // Control state with reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg    <= LEN_BITS'(maf_pkg::LEN_RESET);
            pos_reg    <= '0;
            total_reg  <= '0;
            full_reg   <= 1'b0;
            cnt_reg    <= '0;
            tvalid_reg <= 1'b0;
        end
        else
        begin
            len_reg    <= len_next;
            pos_reg    <= pos_next;
            total_reg  <= total_next;
            full_reg   <= full_next;
            cnt_reg    <= cnt_next;
            tvalid_reg <= tvalid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        sample_reg   <= sample_next;
        held_reg     <= held_next;
        neg_reg      <= neg_next;
        dvd_reg      <= dvd_next;
        rem_reg      <= rem_next;
        avg_reg      <= avg_next;
        held_out_reg <= held_out_next;
    end

    // Status and outputs.
    assign sts.div_last  = (cnt_reg == CNT_BITS'(TOTAL_BITS - 1));
    assign sts.out_free  = !tvalid_reg || m_tready;
    assign m_tvalid      = tvalid_reg;
    assign average       = avg_reg;
    assign samples_held  = held_out_reg;

    // The divisor is never zero and never exceeds the window length.
    `MAF_ASSERT_SAME(a_held_range, cmd.load_div,
        (held_reg != '0) && (held_reg <= len_reg), "divisor out of range")

    // The write position stays inside the window.
    `MAF_ASSERT_SAME(a_pos_range, cmd.load_div,
        CMP_BITS'(pos_reg) < CMP_BITS'(len_reg), "write position beyond window")

    // A loaded result is offered in the next cycle.
    `MAF_ASSERT_NEXT(a_result_shown, cmd.load_out, m_tvalid,
        "loaded result not offered")

endmodule
